// ----- rtl/core/radial_velocity_integrator_core_assert.svh -----
// Assertion macros shared by the radial velocity integrator RTL.
`ifndef RADIAL_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH
`define RADIAL_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define RVI_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds after ante, delayed by the n argument.
`define RVI_ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rvi_pkg.sv -----
// Package with the types, constants and helpers of the radial velocity integrator.
package rvi_pkg;

    localparam int RVI_WORD_BITS = 32;
    localparam int RVI_FRAC_BITS = 16;
    localparam int RVI_STEP_BITS = 16;
    localparam int RVI_ROOT_BITS = 32;
    localparam logic [RVI_STEP_BITS-1:0] RVI_TIME_STEP_RESET = 16'd1092;

    typedef struct packed {
        logic signed [RVI_WORD_BITS-1:0] pos_x;
        logic signed [RVI_WORD_BITS-1:0] pos_y;
        logic signed [RVI_WORD_BITS-1:0] accel_magnitude;
        logic signed [RVI_WORD_BITS-1:0] vel_x;
        logic signed [RVI_WORD_BITS-1:0] vel_y;
        logic                            last_particle;
    } rvi_in_t;

    typedef struct packed {
        logic signed [RVI_WORD_BITS-1:0] new_vel_x;
        logic signed [RVI_WORD_BITS-1:0] new_vel_y;
        logic                            batch_end;
    } rvi_out_t;

    // Per-item data that rides along the pipeline next to the arithmetic.
    typedef struct packed {
        logic [RVI_WORD_BITS-1:0]        mag_x;
        logic [RVI_WORD_BITS-1:0]        mag_y;
        logic [RVI_WORD_BITS-1:0]        mag_accel;
        logic signed [RVI_WORD_BITS-1:0] vel_x;
        logic signed [RVI_WORD_BITS-1:0] vel_y;
        logic                            neg_x;
        logic                            neg_y;
        logic                            last;
    } rvi_side_t;

    function automatic logic [RVI_WORD_BITS-1:0] rvi_mag(
        input logic signed [RVI_WORD_BITS-1:0] v
    );
        logic [RVI_WORD_BITS-1:0] u;
        u = v;
        rvi_mag = v[RVI_WORD_BITS-1] ? (~u + {{(RVI_WORD_BITS-1){1'b0}}, 1'b1}) : u;
    endfunction

endpackage

// ----- rtl/core/radial_velocity_integrator_core.sv -----
// Top level of the radial velocity integrator: one particle velocity update per item.
//
// Usage:
//   Items enter on the particle port. An item is taken at a rising edge with start high
//   and busy low; busy is never raised, so a new particle may enter in every cycle.
//   Each item gives exactly one result on the result port, shown for one cycle with
//   done high. Results leave in the order the items entered.
//   Throughput is one item per cycle. The pipeline holds the 32 stages of the square root,
//   one root bit each, and the FRAC_BITS + 1 stages of the divider, one quotient bit each.
//   The time step is written on the cfg channel (cfg_valid, cfg_ready, cfg_data); cfg_ready
//   is always high. Write it only while no item is in flight.
//   Reset empties the pipeline and sets the time step to 1092 (about 1/60 s).
//   The receiver cannot stall: each result is valid for its one done cycle only.
module radial_velocity_integrator_core #(
    parameter int FRAC_BITS = rvi_pkg::RVI_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rvi_pkg::rvi_in_t                   particle,
    output logic                               done,
    output rvi_pkg::rvi_out_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rvi_pkg::RVI_STEP_BITS-1:0]  cfg_data
);
    import rvi_pkg::*;

    `include "radial_velocity_integrator_core_assert.svh"

    localparam int W       = RVI_WORD_BITS;
    localparam int LATENCY = 3 + RVI_ROOT_BITS + (FRAC_BITS + 1) + 3;

    logic                      accept;
    logic [RVI_STEP_BITS-1:0]  ts_reg;

    logic                      s0_valid_reg;
    rvi_side_t                 s0_side_reg;
    rvi_side_t                 s0_side_next;

    logic                      s1_valid_reg;
    rvi_side_t                 s1_side_reg;
    logic [2*W-1:0]            sq_x_reg;
    logic [2*W-1:0]            sq_y_reg;
    logic [2*W-1:0]            sq_x_next;
    logic [2*W-1:0]            sq_y_next;

    logic                      s2_valid_reg;
    rvi_side_t                 s2_side_reg;
    logic [2*W-1:0]            rad_reg;
    logic [2*W-1:0]            rad_next;

    logic                      sqrt_valid;
    logic [RVI_ROOT_BITS-1:0]  sqrt_root;
    rvi_side_t                 sqrt_side;

    logic                      div_valid;
    logic [FRAC_BITS:0]        div_unit_x;
    logic [FRAC_BITS:0]        div_unit_y;
    rvi_side_t                 div_side;

    logic                      m1_valid_reg;
    rvi_side_t                 m1_side_reg;
    logic [W-1:0]              acc_x_reg;
    logic [W-1:0]              acc_y_reg;
    logic [W+FRAC_BITS:0]      prod_x;
    logic [W+FRAC_BITS:0]      prod_y;
    logic [W-1:0]              acc_x_next;
    logic [W-1:0]              acc_y_next;

    logic                      m2_valid_reg;
    rvi_side_t                 m2_side_reg;
    logic [W-1:0]              delta_x_reg;
    logic [W-1:0]              delta_y_reg;
    logic [W+RVI_STEP_BITS-1:0] step_x;
    logic [W+RVI_STEP_BITS-1:0] step_y;
    logic [W-1:0]              delta_x_next;
    logic [W-1:0]              delta_y_next;

    logic                      done_reg;
    rvi_out_t                  result_reg;
    rvi_out_t                  result_next;

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] v,
        input logic [W-1:0]        d,
        input logic                neg
    );
        logic signed [W+1:0] ve;
        logic signed [W+1:0] de;
        logic signed [W+1:0] s;
        ve = {{2{v[W-1]}}, v};
        de = {2'b00, d};
        s  = neg ? (ve - de) : (ve + de);
        if ((s[W+1:W-1] == 3'b000) || (s[W+1:W-1] == 3'b111))
        begin
            sat_add = s[W-1:0];
        end
        else if (s[W+1] == 1'b0)
        begin
            sat_add = {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            sat_add = {1'b1, {(W-1){1'b0}}};
        end
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= RVI_TIME_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ts_reg <= cfg_data;
        end
    end

    always_comb
    begin
        s0_side_next.mag_x     = rvi_mag(particle.pos_x);
        s0_side_next.mag_y     = rvi_mag(particle.pos_y);
        s0_side_next.mag_accel = rvi_mag(particle.accel_magnitude);
        s0_side_next.vel_x     = particle.vel_x;
        s0_side_next.vel_y     = particle.vel_y;
        s0_side_next.neg_x     = particle.pos_x[W-1] ^ particle.accel_magnitude[W-1];
        s0_side_next.neg_y     = particle.pos_y[W-1] ^ particle.accel_magnitude[W-1];
        s0_side_next.last      = particle.last_particle;
    end

    assign sq_x_next = s0_side_reg.mag_x * s0_side_reg.mag_x;
    assign sq_y_next = s0_side_reg.mag_y * s0_side_reg.mag_y;
    assign rad_next  = sq_x_reg + sq_y_reg;

    rvi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .radicand  (rad_reg),
        .in_side   (s2_side_reg),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    rvi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (div_valid),
        .unit_x    (div_unit_x),
        .unit_y    (div_unit_y),
        .out_side  (div_side)
    );

    assign prod_x       = div_side.mag_accel * div_unit_x;
    assign prod_y       = div_side.mag_accel * div_unit_y;
    assign acc_x_next   = prod_x[FRAC_BITS +: W];
    assign acc_y_next   = prod_y[FRAC_BITS +: W];

    assign step_x       = acc_x_reg * ts_reg;
    assign step_y       = acc_y_reg * ts_reg;
    assign delta_x_next = step_x[RVI_STEP_BITS +: W];
    assign delta_y_next = step_y[RVI_STEP_BITS +: W];

    always_comb
    begin
        result_next.new_vel_x = sat_add(m2_side_reg.vel_x, delta_x_reg, m2_side_reg.neg_x);
        result_next.new_vel_y = sat_add(m2_side_reg.vel_y, delta_y_reg, m2_side_reg.neg_y);
        result_next.batch_end = m2_side_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            m1_valid_reg <= div_valid;
            m2_valid_reg <= m1_valid_reg;
            done_reg     <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_side_reg <= s0_side_next;
        s1_side_reg <= s0_side_reg;
        sq_x_reg    <= sq_x_next;
        sq_y_reg    <= sq_y_next;
        s2_side_reg <= s1_side_reg;
        rad_reg     <= rad_next;
        m1_side_reg <= div_side;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        m2_side_reg <= m1_side_reg;
        delta_x_reg <= delta_x_next;
        delta_y_reg <= delta_y_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RVI_ASSERT_AFTER(a_latency, clk, rst_n, accept, LATENCY, done,
        "result missing after the pipeline latency")
    `RVI_ASSERT_AFTER(a_batch_end, clk, rst_n, accept, LATENCY,
        result.batch_end == $past(particle.last_particle, LATENCY),
        "batch end flag does not follow its item")
    `RVI_ASSERT_AFTER(a_zero_accel_x, clk, rst_n, accept && (particle.accel_magnitude == '0),
        LATENCY, result.new_vel_x == $past(particle.vel_x, LATENCY),
        "zero acceleration changed velocity x")
    `RVI_ASSERT_AFTER(a_zero_accel_y, clk, rst_n, accept && (particle.accel_magnitude == '0),
        LATENCY, result.new_vel_y == $past(particle.vel_y, LATENCY),
        "zero acceleration changed velocity y")

endmodule

// ----- rtl/core/rvi_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband data.
module rvi_sqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [2*rvi_pkg::RVI_ROOT_BITS-1:0]  radicand,
    input  rvi_pkg::rvi_side_t                   in_side,
    output logic                                 out_valid,
    output logic [rvi_pkg::RVI_ROOT_BITS-1:0]    root,
    output rvi_pkg::rvi_side_t                   out_side
);
    import rvi_pkg::*;

    localparam int N  = RVI_ROOT_BITS;
    localparam int RW = N + 2;

    logic             valid_reg [0:N-1];
    logic [RW-1:0]    rem_reg   [0:N-1];
    logic [N-1:0]     root_reg  [0:N-1];
    logic [2*N-1:0]   rad_reg   [0:N-1];
    rvi_side_t        side_reg  [0:N-1];

    logic             valid_prev [0:N-1];
    logic [RW-1:0]    rem_prev   [0:N-1];
    logic [N-1:0]     root_prev  [0:N-1];
    logic [2*N-1:0]   rad_prev   [0:N-1];
    rvi_side_t        side_prev  [0:N-1];

    logic [RW-1:0]    rem_next   [0:N-1];
    logic [N-1:0]     root_next  [0:N-1];

    always_comb
    begin
        valid_prev[0] = in_valid;
        rem_prev[0]   = '0;
        root_prev[0]  = '0;
        rad_prev[0]   = radicand;
        side_prev[0]  = in_side;
        for (int k = 1; k < N; k++)
        begin
            valid_prev[k] = valid_reg[k-1];
            rem_prev[k]   = rem_reg[k-1];
            root_prev[k]  = root_reg[k-1];
            rad_prev[k]   = rad_reg[k-1];
            side_prev[k]  = side_reg[k-1];
        end
    end

    // Each stage brings down the next two radicand bits and tries one root bit.
    always_comb
    begin
        logic [RW+1:0] cand;
        logic [RW+1:0] trial;
        logic          take;
        for (int k = 0; k < N; k++)
        begin
            cand         = {rem_prev[k], rad_prev[k][2*N-1-2*k -: 2]};
            trial        = {{(RW-N){1'b0}}, root_prev[k], 2'b01};
            take         = (cand >= trial);
            rem_next[k]  = take ? RW'(cand - trial) : RW'(cand);
            root_next[k] = {root_prev[k][N-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_prev[k];
            side_reg[k] <= side_prev[k];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ----- rtl/core/rvi_div.sv -----
// Pipelined restoring divider that forms both unit vector components.
module rvi_div #(
    parameter int FRAC_BITS = rvi_pkg::RVI_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [rvi_pkg::RVI_ROOT_BITS-1:0]  root,
    input  rvi_pkg::rvi_side_t                 in_side,
    output logic                               out_valid,
    output logic [FRAC_BITS:0]                 unit_x,
    output logic [FRAC_BITS:0]                 unit_y,
    output rvi_pkg::rvi_side_t                 out_side
);
    import rvi_pkg::*;

    `include "radial_velocity_integrator_core_assert.svh"

    localparam int Q  = FRAC_BITS + 1;
    localparam int RB = RVI_ROOT_BITS;
    localparam logic [Q-1:0] UNIT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic           valid_reg [0:Q-1];
    logic [RB-1:0]  rem_x_reg [0:Q-1];
    logic [RB-1:0]  rem_y_reg [0:Q-1];
    logic [Q-1:0]   quo_x_reg [0:Q-1];
    logic [Q-1:0]   quo_y_reg [0:Q-1];
    logic [RB-1:0]  root_reg  [0:Q-1];
    rvi_side_t      side_reg  [0:Q-1];

    logic           valid_prev [0:Q-1];
    logic [RB-1:0]  rem_x_prev [0:Q-1];
    logic [RB-1:0]  rem_y_prev [0:Q-1];
    logic [Q-1:0]   quo_x_prev [0:Q-1];
    logic [Q-1:0]   quo_y_prev [0:Q-1];
    logic [RB-1:0]  root_prev  [0:Q-1];
    rvi_side_t      side_prev  [0:Q-1];

    logic [RB-1:0]  rem_x_next [0:Q-1];
    logic [RB-1:0]  rem_y_next [0:Q-1];
    logic [Q-1:0]   quo_x_next [0:Q-1];
    logic [Q-1:0]   quo_y_next [0:Q-1];

    // Since the quotient is at most one, the upper dividend bits start below the divisor.
    always_comb
    begin
        valid_prev[0] = in_valid;
        rem_x_prev[0] = {1'b0, in_side.mag_x[RB-1:1]};
        rem_y_prev[0] = {1'b0, in_side.mag_y[RB-1:1]};
        quo_x_prev[0] = '0;
        quo_y_prev[0] = '0;
        root_prev[0]  = root;
        side_prev[0]  = in_side;
        for (int k = 1; k < Q; k++)
        begin
            valid_prev[k] = valid_reg[k-1];
            rem_x_prev[k] = rem_x_reg[k-1];
            rem_y_prev[k] = rem_y_reg[k-1];
            quo_x_prev[k] = quo_x_reg[k-1];
            quo_y_prev[k] = quo_y_reg[k-1];
            root_prev[k]  = root_reg[k-1];
            side_prev[k]  = side_reg[k-1];
        end
    end

    always_comb
    begin
        logic [RB:0] cand_x;
        logic [RB:0] cand_y;
        logic [RB:0] dvs;
        logic        nz;
        logic        take_x;
        logic        take_y;
        logic        bit_x;
        logic        bit_y;
        for (int k = 0; k < Q; k++)
        begin
            bit_x         = (k == 0) ? side_prev[k].mag_x[0] : 1'b0;
            bit_y         = (k == 0) ? side_prev[k].mag_y[0] : 1'b0;
            dvs           = {1'b0, root_prev[k]};
            nz            = (root_prev[k] != '0);
            cand_x        = {rem_x_prev[k], bit_x};
            cand_y        = {rem_y_prev[k], bit_y};
            take_x        = nz && (cand_x >= dvs);
            take_y        = nz && (cand_y >= dvs);
            rem_x_next[k] = take_x ? RB'(cand_x - dvs) : RB'(cand_x);
            rem_y_next[k] = take_y ? RB'(cand_y - dvs) : RB'(cand_y);
            quo_x_next[k] = {quo_x_prev[k][Q-2:0], take_x};
            quo_y_next[k] = {quo_y_prev[k][Q-2:0], take_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < Q; k++)
            begin
                valid_reg[k] <= valid_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q; k++)
        begin
            rem_x_reg[k] <= rem_x_next[k];
            rem_y_reg[k] <= rem_y_next[k];
            quo_x_reg[k] <= quo_x_next[k];
            quo_y_reg[k] <= quo_y_next[k];
            root_reg[k]  <= root_prev[k];
            side_reg[k]  <= side_prev[k];
        end
    end

    assign out_valid = valid_reg[Q-1];
    assign unit_x    = quo_x_reg[Q-1];
    assign unit_y    = quo_y_reg[Q-1];
    assign out_side  = side_reg[Q-1];

    `RVI_ASSERT_IMPLIES(a_unit_bound, clk, rst_n, out_valid,
        (unit_x <= UNIT_ONE) && (unit_y <= UNIT_ONE), "unit vector component above one")
    `RVI_ASSERT_IMPLIES(a_zero_length, clk, rst_n, out_valid && (root_reg[Q-1] == '0),
        (unit_x == '0) && (unit_y == '0), "zero length gave a nonzero unit vector")
    `RVI_ASSERT_AFTER(a_div_latency, clk, rst_n, in_valid, Q, out_valid,
        "item lost in the divider pipeline")

endmodule

// ----- test/radial_velocity_integrator_core_test.sv -----
// Self-checking testbench for the radial velocity integrator core with randomized gaps in all but one phase.
module radial_velocity_integrator_core_test;
    import rvi_pkg::*;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    rvi_in_t                  particle = '0;
    logic                     done;
    rvi_out_t                 result;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [RVI_STEP_BITS-1:0] cfg_data = '0;

    rvi_in_t                  pending_particles[$];
    rvi_out_t                 expected_velocities[$];
    logic [RVI_STEP_BITS-1:0] time_step = RVI_TIME_STEP_RESET;
    logic                     gaps_on = 1'b1;
    int                       error_count = 0;

    radial_velocity_integrator_core uut (.*);

    function automatic logic [63:0] isqrt_floor(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= s)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] step_component(
        input logic signed [31:0] p,
        input logic [63:0]        r,
        input logic signed [31:0] m,
        input logic signed [31:0] v,
        input logic [15:0]        dt
    );
        logic signed [63:0] wide_p;
        logic signed [63:0] wide_m;
        logic [63:0]        mag_p;
        logic [63:0]        mag_m;
        logic [63:0]        unit;
        logic [63:0]        accel;
        logic [63:0]        delta;
        logic signed [63:0] sum;
        wide_p = p;
        wide_m = m;
        sum = v;
        if (r != 0 && p != 0 && m != 0)
        begin
            mag_p = (wide_p < 0) ? -wide_p : wide_p;
            mag_m = (wide_m < 0) ? -wide_m : wide_m;
            unit = (mag_p << RVI_FRAC_BITS) / r;
            accel = (mag_m * unit) >> RVI_FRAC_BITS;
            delta = (accel * dt) >> RVI_STEP_BITS;
            if ((p < 0) != (m < 0))
                sum = sum - signed'(delta);
            else
                sum = sum + signed'(delta);
        end
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        else if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function automatic rvi_out_t predict_velocity(input rvi_in_t it, input logic [15:0] dt);
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [63:0]        r;
        rvi_out_t           o;
        px = $signed(it.pos_x);
        py = $signed(it.pos_y);
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        r = isqrt_floor(ax * ax + ay * ay);
        o.new_vel_x = step_component(it.pos_x, r, it.accel_magnitude, it.vel_x, dt);
        o.new_vel_y = step_component(it.pos_y, r, it.accel_magnitude, it.vel_y, dt);
        o.batch_end = it.last_particle;
        return o;
    endfunction

    task automatic check_velocity(input rvi_out_t want, input rvi_out_t got);
        if (got.new_vel_x !== want.new_vel_x)
        begin
            error_count++;
            $display("%0t: new_vel_x expected %h actual %h", $time, want.new_vel_x,
                got.new_vel_x);
        end
        if (got.new_vel_y !== want.new_vel_y)
        begin
            error_count++;
            $display("%0t: new_vel_y expected %h actual %h", $time, want.new_vel_y,
                got.new_vel_y);
        end
        if (got.batch_end !== want.batch_end)
        begin
            error_count++;
            $display("%0t: batch_end expected %b actual %b", $time, want.batch_end,
                got.batch_end);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_particle(
        input logic [31:0] px,
        input logic [31:0] py,
        input logic [31:0] m,
        input logic [31:0] vx,
        input logic [31:0] vy,
        input logic        last
    );
        rvi_in_t it;
        it.pos_x = px;
        it.pos_y = py;
        it.accel_magnitude = m;
        it.vel_x = vx;
        it.vel_y = vy;
        it.last_particle = last;
        pending_particles.push_back(it);
    endtask

    task automatic add_random(input int count);
        repeat (count)
            add_particle(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                $urandom_range(7) == 0);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_particles.size() != 0 || start || expected_velocities.size() != 0);
    endtask

    task automatic write_step(input logic [RVI_STEP_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        time_step = value;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            particle <= '0;
        end
        else if (!start || !busy)
        begin
            if (pending_particles.size() != 0 && !(gaps_on && $urandom_range(99) < 22))
            begin
                start <= 1'b1;
                particle <= pending_particles.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_velocities.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, result);
                end
                else
                    check_velocity(expected_velocities.pop_front(), result);
            end
            if (start && !busy)
                expected_velocities.push_back(predict_velocity(particle, time_step));
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_particle(32'h0, 32'h0, 32'h0001_0000, 32'h0001_2345, 32'hFFFA_BCDF, 1'b1);
        add_particle(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        add_particle(32'h0, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 1'b1);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 1'b0);
        add_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 1'b1);
        add_particle(32'h1, 32'h1, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
        add_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        add_particle(32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0000_1000,
            32'hFFFF_F000, 1'b0);
        add_particle(32'hFFFD_0000, 32'h0004_0000, 32'hFFFB_0000, 32'h0, 32'h0, 1'b1);
        add_particle(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_particle(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FF0_0000, 32'h0, 1'b0);
        add_particle(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8010_0000, 32'h0, 1'b0);
        add_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1);
        add_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
            32'h0F0F_0F0F, 1'b0);
        drain();

        write_step(16'hFFFF);
        add_random(150);
        drain();
        write_step(16'h0000);
        add_random(100);
        drain();
        write_step(16'h0001);
        add_random(100);
        drain();
        write_step(16'($urandom));
        gaps_on = 1'b0;
        add_random(200);
        drain();
        gaps_on = 1'b1;
        write_step(16'h8000);
        add_random(150);
        drain();
        write_step(RVI_TIME_STEP_RESET);
        add_random(150);
        drain();

        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
